// ===== hw/rtl/blas1_pkg.sv =====
package blas1_pkg;

  localparam int ElemBits = 32;
  localparam int FracBits = 16;
  localparam int NormBits = 48;
  localparam int AccBits  = 64;
  localparam int ProdBits = 2 * ElemBits;
  localparam int SumBits  = ProdBits + 2;

  typedef enum logic [2:0] {
    OP_SCALE = 3'd0,
    OP_AXPY  = 3'd1,
    OP_AXPBY = 3'd2,
    OP_MUL   = 3'd3,
    OP_RECIP = 3'd4,
    OP_L1    = 3'd5,
    OP_L2    = 3'd6,
    OP_MAX   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    REG_OPERATION = 2'd0,
    REG_ALPHA     = 2'd1,
    REG_BETA      = 2'd2,
    REG_EPSILON   = 2'd3
  } reg_idx_t;

  // Request from the sequencer to the shared shift-subtract unit.
  typedef struct packed {
    logic                start;
    logic                is_sqrt;
    logic [AccBits-1:0]  operand;
  } iter_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [AccBits-1:0]  result;
  } iter_rsp_t;

endpackage

// ===== hw/rtl/blas1_iter.sv =====
module blas1_iter (
  input  logic                  clk,
  input  logic                  rst,
  input  blas1_pkg::iter_req_t  req,
  output blas1_pkg::iter_rsp_t  rsp
);
  import blas1_pkg::*;

  localparam int CntBits = 6;

  logic               busy;
  logic               done;
  logic               is_sqrt;
  logic [CntBits-1:0] cnt;
  logic [AccBits-1:0] rem;
  logic [AccBits-1:0] quo;
  logic [AccBits-1:0] dvs;
  logic [AccBits-1:0] num;
  logic [AccBits:0]   trial;
  logic [AccBits-1:0] cand;
  logic [AccBits-1:0] rem_sh;

  // Restoring division of 2^(2F) by dvs, or a digit-pair square root of num.
  always_comb begin
    if (is_sqrt) begin
      rem_sh = {rem[AccBits-3:0], num[AccBits-1 -: 2]};
      cand   = {quo[AccBits-3:0], 2'b01};
    end else begin
      rem_sh = {rem[AccBits-2:0], num[AccBits-1]};
      cand   = dvs;
    end
    trial = {1'b0, rem_sh} - {1'b0, cand};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        is_sqrt <= req.is_sqrt;
        rem     <= '0;
        quo     <= '0;
        if (req.is_sqrt) begin
          num <= req.operand;
          dvs <= '0;
          cnt <= CntBits'(AccBits / 2 - 1);
        end else begin
          // The dividend bits enter from the top: a one followed by 2F zeros.
          num <= AccBits'(1) << (AccBits - 1);
          dvs <= req.operand;
          cnt <= CntBits'(2 * FracBits);
        end
      end else if (busy) begin
        num <= is_sqrt ? {num[AccBits-3:0], 2'b00} : {num[AccBits-2:0], 1'b0};
        if (!trial[AccBits]) begin
          rem <= trial[AccBits-1:0];
          quo <= {quo[AccBits-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[AccBits-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = quo;
endmodule

// ===== hw/rtl/blas1_vector_stream_unit.sv =====
// BLAS level-1 vector stream unit, signed Q16.16.
// s_axis carries one item per word: tdata = {second_element, first_element}
// and tlast = last_element. m_axis returns exactly one result word per item:
// tdata = {norm_value, element_result}, tuser = {saturated, norm_valid}.
// The cfg channel writes operation, alpha, beta and epsilon by index; the
// user must write them only while the unit is idle, which the unit itself
// does not enforce. An index beyond the list is ignored. Each item runs
// through a small sequencer that uses one 32x32 multiplier for the products
// (two products for axpby) and one shift-subtract unit for the reciprocal
// (33 iterations) and the L2 square root (32 iterations). The next item is
// accepted at the earliest in the cycle after the result word of the
// previous item is taken.
// s_axis_tready is high only while no item is in work and the output
// register is free; a stalled receiver holds the result in that register
// and blocks the next item. Reset returns the registers to operation 0,
// alpha 1.0, beta 0, epsilon 0 and clears the norm accumulator.
module blas1_vector_stream_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // first_element[31:0], second_element[63:32]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // element_result[31:0], norm_value[79:32]
  output logic [1:0]  m_axis_tuser,  // norm_valid[0], saturated[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import blas1_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_FIN  = 6'b001000,
    S_ITER = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  op_t    operation;
  logic signed [ElemBits-1:0] alpha, beta;
  logic [ElemBits-2:0] epsilon;
  logic [AccBits-1:0]  norm_accumulator;
  logic signed [ElemBits-1:0] x, y;
  logic last;
  logic [ElemBits:0] ux;
  logic signed [SumBits-1:0] sum;
  logic signed [ProdBits-1:0] prod;
  logic signed [ElemBits-1:0] mul_a, mul_b;

  logic [ElemBits-1:0] element_result;
  logic [NormBits-1:0] norm_value;
  logic norm_valid, saturated, out_valid;

  iter_req_t req;
  iter_rsp_t rsp;

  blas1_iter u_iter (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {norm_value, element_result};
  assign m_axis_tuser  = {saturated, norm_valid};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = x;
    mul_b = y;
    if (state == S_MUL1) begin
      unique case (operation)
        OP_SCALE, OP_AXPY, OP_AXPBY: begin mul_a = alpha; mul_b = x; end
        OP_L2:                       begin mul_a = x;     mul_b = x; end
        default:                     begin mul_a = x;     mul_b = y; end
      endcase
    end else begin
      mul_a = beta;
      mul_b = y;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  logic signed [SumBits-1:0] shr;
  logic [AccBits:0] l1_sum;
  logic [AccBits:0] l2_sum;
  logic [AccBits-1:0] acc_new;
  logic [ElemBits:0] half;

  always_comb begin
    shr    = sum >>> FracBits;
    l1_sum = {1'b0, norm_accumulator} + (AccBits+1)'(ux);
    l2_sum = {1'b0, norm_accumulator} + {1'b0, prod};
    half   = (ElemBits+1)'(1) << (ElemBits - 1);
    acc_new = norm_accumulator;
    unique case (operation)
      OP_L1:   acc_new = l1_sum[AccBits] ? '1 : l1_sum[AccBits-1:0];
      OP_L2:   acc_new = l2_sum[AccBits] ? '1 : l2_sum[AccBits-1:0];
      default: if (AccBits'(ux) > norm_accumulator) acc_new = AccBits'(ux);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      operation        <= OP_SCALE;
      alpha            <= ElemBits'(1) <<< FracBits;
      beta             <= '0;
      epsilon          <= '0;
      norm_accumulator <= '0;
      req              <= '0;
    end else begin
      req.start <= 1'b0;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_OPERATION: operation <= op_t'(cfg_data[2:0]);
          REG_ALPHA:     alpha     <= cfg_data;
          REG_BETA:      beta      <= cfg_data;
          REG_EPSILON:   epsilon   <= cfg_data[ElemBits-2:0];
          default: ;
        endcase
      end
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          x     <= s_axis_tdata[31:0];
          y     <= s_axis_tdata[63:32];
          last  <= s_axis_tlast;
          ux    <= s_axis_tdata[31] ? (ElemBits+1)'(-{1'b1, s_axis_tdata[31:0]})
                                    : {1'b0, s_axis_tdata[31:0]};
          element_result <= '0;
          norm_value     <= '0;
          norm_valid     <= 1'b0;
          saturated      <= 1'b0;
          state <= S_MUL1;
        end
        S_MUL1: begin
          // Product of the operands is registered this cycle.
          if (operation == OP_RECIP) begin
            if (ux > (ElemBits+1)'(epsilon)) begin
              req.start   <= 1'b1;
              req.is_sqrt <= 1'b0;
              req.operand <= AccBits'(ux);
              state <= S_ITER;
            end else begin
              element_result <= x;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          unique case (operation)
            OP_AXPY:  sum <= SumBits'(prod) + (SumBits'(y) <<< FracBits);
            default:  sum <= SumBits'(prod);
          endcase
          state <= (operation == OP_AXPBY) ? S_FIN : S_OUT;
          if (operation == OP_L1 || operation == OP_L2 || operation == OP_MAX) begin
            norm_accumulator <= acc_new;
            if (last) begin
              norm_valid <= 1'b1;
              norm_accumulator <= '0;
              if (acc_new == '1 ||
                  (operation != OP_L2 && acc_new[AccBits-1:NormBits] != '0)) begin
                norm_value <= '1;
                saturated  <= 1'b1;
                out_valid  <= 1'b1;
                state <= S_IDLE;
              end else if (operation == OP_L2) begin
                req.start   <= 1'b1;
                req.is_sqrt <= 1'b1;
                req.operand <= acc_new;
                state <= S_ITER;
              end else begin
                norm_value <= acc_new[NormBits-1:0];
                out_valid  <= 1'b1;
                state <= S_IDLE;
              end
            end else begin
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          // beta*y is in prod now.
          sum <= sum + SumBits'(prod);
          state <= S_OUT;
        end
        S_OUT: begin
          if (shr > $signed(SumBits'(half - 1'b1))) begin
            element_result <= ElemBits'(half - 1'b1);
            saturated <= 1'b1;
          end else if (shr < -$signed(SumBits'(half))) begin
            element_result <= ElemBits'(half);
            saturated <= 1'b1;
          end else begin
            element_result <= shr[ElemBits-1:0];
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_ITER: if (rsp.done) begin
          if (operation == OP_L2) begin
            norm_value <= rsp.result[NormBits-1:0];
          end else if (!x[ElemBits-1]) begin
            if (rsp.result > AccBits'(half - 1'b1)) begin
              element_result <= ElemBits'(half - 1'b1);
              saturated <= 1'b1;
            end else element_result <= rsp.result[ElemBits-1:0];
          end else begin
            if (rsp.result > AccBits'(half)) begin
              element_result <= ElemBits'(half);
              saturated <= 1'b1;
            end else element_result <= -rsp.result[ElemBits-1:0];
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
